/* rtl/gray_box_downsample_unit_defines.svh */
// Assertion macros shared by the gray box downsample RTL.
`ifndef GRAY_BOX_DOWNSAMPLE_UNIT_DEFINES_SVH
`define GRAY_BOX_DOWNSAMPLE_UNIT_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define GBDS_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante.
`define GBDS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/gbds_pkg.sv */
// Shared types and constants for the gray box downsample unit.
`timescale 1ns / 1ps

package gbds_pkg;

    // Field and counter widths
    localparam int CH_W       = 8;
    localparam int SCALE_W    = 4;
    localparam int CNT_W      = 11;
    localparam int POS_W      = 10;
    localparam int GRAY_W     = 16;
    localparam int SUM_W      = 24;
    localparam int LUMA_W     = 15;

    // Bin size limit and frame row limit
    localparam int MAX_SCALE  = 8;
    localparam int SUB_W      = $clog2(MAX_SCALE);
    localparam int ROW_LIMIT  = 1024;

    // Luma weights: 0.30, 0.58, 0.11 scaled by 100; full scale 255 * 100
    localparam int LUMA_R     = 30;
    localparam int LUMA_G     = 58;
    localparam int LUMA_B     = 11;
    localparam int DIV_BASE   = 25500;
    localparam int DIV_W      = $clog2(DIV_BASE * MAX_SCALE * MAX_SCALE + 1);
    localparam int STEP_W     = $clog2(GRAY_W);

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS  = 2'd2;

    // Register reset values
    localparam int SCALE_RESET = 2;
    localparam int COLS_RESET  = 640;
    localparam int ROWS_RESET  = 480;

    // Clamped configuration with the bin divisor 25500 * S * S
    typedef struct packed {
        logic [SCALE_W-1:0] scale;
        logic [CNT_W-1:0]   cols;
        logic [CNT_W-1:0]   rows;
        logic [DIV_W-1:0]   divisor;
    } cfg_t;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;
        logic accumulate;
        logic prep;
        logic step;
        logic load_out;
    } dp_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic emit;
        logic out_free;
    } dp_status_t;

endpackage

/* rtl/gray_box_downsample_unit.sv */
// Top level of the RGB to gray box-filter downscaler.
`timescale 1ns / 1ps

// Takes RGB pixels in raster order, forms luma 30R+58G+11B per pixel and sums it over
// square S x S bins in a line of MAX_COLS accumulator words, one per bin column; the
// first pixel of each bin overwrites its word, so the line needs no clearing after
// reset. When a bin completes, its mean is sent as an unsigned Q0.16 fraction of full
// scale, rounded half up, with its downscaled column and row and a flag on the last
// bin of each downscaled row. Pixels right of the last whole bin and rows below the
// last whole bin row are dropped. A pixel that completes no bin takes an accumulator
// read, then an add and write back; a pixel that completes a bin goes on to a setup
// step, the radix-2 quotient unit that produces one result bit per cycle, and the
// handoff of the word to the output register. The output register holds a finished
// word until it is taken while new pixels keep flowing in; a further bin result waits
// only if that word is still held.
// Configuration writes are taken in any cycle and are meant for an idle block.
module gray_box_downsample_unit import gbds_pkg::*;
#(
    parameter int MAX_COLS = 1024
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [CH_W-1:0]       red,
    input  logic [CH_W-1:0]       green,
    input  logic [CH_W-1:0]       blue,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [GRAY_W-1:0]     gray,
    output logic [POS_W-1:0]      out_col,
    output logic [POS_W-1:0]      out_row,
    output logic                  row_done
);

    cfg_t       cfg;
    dp_cmd_t    cmd;
    dp_status_t status;

    // Configuration registers
    gbds_cfg #(
        .MAX_COLS (MAX_COLS)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Sequencer
    gbds_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // Datapath
    gbds_datapath #(
        .MAX_COLS (MAX_COLS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .cmd       (cmd),
        .status    (status),
        .red       (red),
        .green     (green),
        .blue      (blue),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .gray      (gray),
        .out_col   (out_col),
        .out_row   (out_row),
        .row_done  (row_done)
    );

endmodule

/* rtl/gbds_cfg.sv */
// Configuration registers, stored clamped, with the derived bin divisor.
`timescale 1ns / 1ps

module gbds_cfg import gbds_pkg::*;
#(
    parameter int MAX_COLS = 1024
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    localparam int COLS_INIT = (COLS_RESET > MAX_COLS) ? MAX_COLS : COLS_RESET;

    logic [SCALE_W-1:0]   scale_reg;
    logic [CNT_W-1:0]     cols_reg;
    logic [CNT_W-1:0]     rows_reg;
    logic [DIV_W-1:0]     divisor_reg;

    logic [SCALE_W-1:0]   scale_in;
    logic [SCALE_W-1:0]   scale_next;
    logic [2*SCALE_W-1:0] scale_sq;
    logic [DIV_W-1:0]     divisor_next;
    logic [CNT_W-1:0]     cols_in;
    logic [CNT_W-1:0]     cols_next;
    logic [CNT_W-1:0]     rows_in;
    logic [CNT_W-1:0]     rows_next;

    assign cfg_ready = 1'b1;

    // Clamp incoming values to their legal ranges
    always_comb
    begin
        scale_in = cfg_data[SCALE_W-1:0];
        if (scale_in == '0)
            scale_next = SCALE_W'(1);
        else if (32'(scale_in) > MAX_SCALE)
            scale_next = SCALE_W'(MAX_SCALE);
        else
            scale_next = scale_in;
        scale_sq     = (2*SCALE_W)'(scale_next) * (2*SCALE_W)'(scale_next);
        divisor_next = DIV_W'(DIV_BASE) * DIV_W'(scale_sq);

        cols_in = cfg_data[CNT_W-1:0];
        if (cols_in == '0)
            cols_next = CNT_W'(1);
        else if (32'(cols_in) > MAX_COLS)
            cols_next = CNT_W'(MAX_COLS);
        else
            cols_next = cols_in;

        rows_in = cfg_data[CNT_W-1:0];
        if (rows_in == '0)
            rows_next = CNT_W'(1);
        else if (32'(rows_in) > ROW_LIMIT)
            rows_next = CNT_W'(ROW_LIMIT);
        else
            rows_next = rows_in;
    end

    // Store the written register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg   <= SCALE_W'(SCALE_RESET);
            divisor_reg <= DIV_W'(DIV_BASE * SCALE_RESET * SCALE_RESET);
            cols_reg    <= CNT_W'(COLS_INIT);
            rows_reg    <= CNT_W'(ROWS_RESET);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_SCALE:
                begin
                    scale_reg   <= scale_next;
                    divisor_reg <= divisor_next;
                end
                CFG_COLS: cols_reg <= cols_next;
                CFG_ROWS: rows_reg <= rows_next;
                default: ;
            endcase
        end
    end

    assign cfg.scale   = scale_reg;
    assign cfg.cols    = cols_reg;
    assign cfg.rows    = rows_reg;
    assign cfg.divisor = divisor_reg;

endmodule

/* rtl/gbds_ctrl.sv */
// Sequencer for pixel capture, accumulation, division and result handoff.
`timescale 1ns / 1ps
`include "gray_box_downsample_unit_defines.svh"

module gbds_ctrl import gbds_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACC,
        ST_PREP,
        ST_DIV,
        ST_EMIT
    } state_t;

    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(GRAY_W - 1);

    state_t              state_reg;
    state_t              state_next;
    logic [STEP_W-1:0]   step_reg;
    logic [STEP_W-1:0]   step_next;

    // Decode commands and the next state
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_ACC;
                end
            end
            ST_ACC:
            begin
                cmd.accumulate = 1'b1;
                state_next     = status.emit ? ST_PREP : ST_IDLE;
            end
            ST_PREP:
            begin
                cmd.prep   = 1'b1;
                step_next  = '0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.step  = 1'b1;
                step_next = step_reg + STEP_W'(1);
                if (step_reg == LAST_STEP)
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Hold state and the quotient step count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    assign in_ready = (state_reg == ST_IDLE);

    `GBDS_ASSERT_NEXT(a_accept_then_acc, in_valid && in_ready, cmd.accumulate, "no accumulate after accept")
    `GBDS_ASSERT_SAME(a_load_needs_slot, cmd.load_out, status.out_free, "output loaded while busy")
    `GBDS_ASSERT_SAME(a_prep_after_emit, cmd.prep, $past(cmd.accumulate) && $past(status.emit), "divide started without a finished bin")

endmodule

/* rtl/gbds_datapath.sv */
// Raster counters, luma, bin accumulator line, quotient unit and output register.
`timescale 1ns / 1ps
`include "gray_box_downsample_unit_defines.svh"

module gbds_datapath import gbds_pkg::*;
#(
    parameter int MAX_COLS = 1024
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  cfg_t              cfg,
    input  dp_cmd_t           cmd,
    output dp_status_t        status,
    input  logic [CH_W-1:0]   red,
    input  logic [CH_W-1:0]   green,
    input  logic [CH_W-1:0]   blue,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [GRAY_W-1:0] gray,
    output logic [POS_W-1:0]  out_col,
    output logic [POS_W-1:0]  out_row,
    output logic              row_done
);

    localparam int ADDR_W = $clog2(MAX_COLS);
    localparam int PROD_W = CNT_W + SCALE_W + 1;
    localparam int CMP_W  = SCALE_W + 1;
    localparam int UP_W   = SUM_W + 1;

    // Accumulator line, one word per bin column
    logic [SUM_W-1:0]   bin_sums [MAX_COLS];

    // Raster position
    logic [CNT_W-1:0]   col_count_reg, col_count_next;
    logic [CNT_W-1:0]   row_count_reg, row_count_next;
    logic [SUB_W-1:0]   sub_col_reg, sub_col_next;
    logic [SUB_W-1:0]   sub_row_reg, sub_row_next;
    logic [CNT_W-1:0]   bin_col_reg, bin_col_next;
    logic [CNT_W-1:0]   bin_row_reg, bin_row_next;

    logic [CNT_W:0]     col_inc;
    logic [CNT_W:0]     row_inc;
    logic [SUB_W:0]     sub_col_inc;
    logic [SUB_W:0]     sub_row_inc;
    logic               sub_col_wrap;
    logic               sub_row_wrap;

    // Capture stage
    logic [PROD_W-1:0]  col_span;
    logic [PROD_W-1:0]  row_span;
    logic [SCALE_W-1:0] scale_m1;
    logic               whole_c;
    logic               first_c;
    logic               last_c;
    logic               rdone_c;
    logic [LUMA_W-1:0]  luma_c;
    logic [ADDR_W-1:0]  addr_c;

    logic [LUMA_W-1:0]  luma_reg;
    logic               first_reg;
    logic               whole_reg;
    logic               emit_reg;
    logic               rdone_reg;
    logic [ADDR_W-1:0]  addr_reg;
    logic [CNT_W-1:0]   bcol_reg;
    logic [CNT_W-1:0]   brow_reg;
    logic [SUM_W-1:0]   rd_reg;

    // Accumulate stage
    logic [SUM_W-1:0]   acc_c;
    logic [SUM_W-1:0]   acc_reg;

    // Quotient unit
    logic [UP_W-1:0]    upper_c;
    logic [DIV_W:0]     trial_c;
    logic [DIV_W:0]     diff_c;
    logic               ge_c;
    logic [DIV_W-1:0]   rem_reg;
    logic [GRAY_W-1:0]  num_reg;
    logic [GRAY_W-1:0]  quo_reg;
    logic               sat_reg;

    // Output register
    logic               out_valid_reg;
    logic [GRAY_W-1:0]  gray_reg;
    logic [POS_W-1:0]   out_col_reg;
    logic [POS_W-1:0]   out_row_reg;
    logic               row_done_reg;

    // Advance the raster position by one pixel
    always_comb
    begin
        col_inc      = {1'b0, col_count_reg} + (CNT_W+1)'(1);
        row_inc      = {1'b0, row_count_reg} + (CNT_W+1)'(1);
        sub_col_inc  = {1'b0, sub_col_reg} + (SUB_W+1)'(1);
        sub_row_inc  = {1'b0, sub_row_reg} + (SUB_W+1)'(1);
        sub_col_wrap = CMP_W'(sub_col_inc) >= CMP_W'(cfg.scale);
        sub_row_wrap = CMP_W'(sub_row_inc) >= CMP_W'(cfg.scale);

        col_count_next = col_count_reg;
        row_count_next = row_count_reg;
        sub_col_next   = sub_col_reg;
        sub_row_next   = sub_row_reg;
        bin_col_next   = bin_col_reg;
        bin_row_next   = bin_row_reg;

        if (cmd.capture)
        begin
            if (col_inc >= {1'b0, cfg.cols})
            begin
                col_count_next = '0;
                sub_col_next   = '0;
                bin_col_next   = '0;
                if (row_inc >= {1'b0, cfg.rows})
                begin
                    row_count_next = '0;
                    sub_row_next   = '0;
                    bin_row_next   = '0;
                end
                else
                begin
                    row_count_next = row_inc[CNT_W-1:0];
                    if (sub_row_wrap)
                    begin
                        sub_row_next = '0;
                        bin_row_next = bin_row_reg + CNT_W'(1);
                    end
                    else
                    begin
                        sub_row_next = sub_row_inc[SUB_W-1:0];
                    end
                end
            end
            else
            begin
                col_count_next = col_inc[CNT_W-1:0];
                if (sub_col_wrap)
                begin
                    sub_col_next = '0;
                    bin_col_next = bin_col_reg + CNT_W'(1);
                end
                else
                begin
                    sub_col_next = sub_col_inc[SUB_W-1:0];
                end
            end
        end
    end

    // Classify the pixel against the current bin
    always_comb
    begin
        col_span = (PROD_W'(bin_col_reg) + PROD_W'(1)) * PROD_W'(cfg.scale);
        row_span = (PROD_W'(bin_row_reg) + PROD_W'(1)) * PROD_W'(cfg.scale);
        whole_c  = (col_span <= PROD_W'(cfg.cols)) && (row_span <= PROD_W'(cfg.rows));
        rdone_c  = (col_span + PROD_W'(cfg.scale)) > PROD_W'(cfg.cols);
        scale_m1 = cfg.scale - SCALE_W'(1);
        first_c  = (sub_col_reg == '0) && (sub_row_reg == '0);
        last_c   = (SCALE_W'(sub_col_reg) == scale_m1) && (SCALE_W'(sub_row_reg) == scale_m1);
        luma_c   = LUMA_W'(red) * LUMA_W'(LUMA_R)
                 + LUMA_W'(green) * LUMA_W'(LUMA_G)
                 + LUMA_W'(blue) * LUMA_W'(LUMA_B);
        addr_c   = ADDR_W'(bin_col_reg);
    end

    // Sum into the bin, restart it on its first pixel
    assign acc_c = first_reg ? SUM_W'(luma_reg) : rd_reg + SUM_W'(luma_reg);

    // Divide step: shift in one numerator bit, subtract when it fits
    always_comb
    begin
        upper_c = UP_W'(acc_reg) + UP_W'(cfg.divisor[DIV_W-1:GRAY_W+1]);
        trial_c = {rem_reg, num_reg[GRAY_W-1]};
        diff_c  = trial_c - {1'b0, cfg.divisor};
        ge_c    = trial_c >= {1'b0, cfg.divisor};
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_count_reg <= '0;
            row_count_reg <= '0;
            sub_col_reg   <= '0;
            sub_row_reg   <= '0;
            bin_col_reg   <= '0;
            bin_row_reg   <= '0;
            whole_reg     <= 1'b0;
            emit_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            col_count_reg <= col_count_next;
            row_count_reg <= row_count_next;
            sub_col_reg   <= sub_col_next;
            sub_row_reg   <= sub_row_next;
            bin_col_reg   <= bin_col_next;
            bin_row_reg   <= bin_row_next;
            if (cmd.capture)
            begin
                whole_reg <= whole_c;
                emit_reg  <= whole_c && last_c;
            end
            if (cmd.load_out)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            luma_reg  <= luma_c;
            first_reg <= first_c;
            rdone_reg <= rdone_c;
            addr_reg  <= addr_c;
            bcol_reg  <= bin_col_reg;
            brow_reg  <= bin_row_reg;
        end
        if (cmd.accumulate)
            acc_reg <= acc_c;
        if (cmd.prep)
        begin
            sat_reg <= upper_c >= UP_W'(cfg.divisor);
            rem_reg <= upper_c[DIV_W-1:0];
            num_reg <= cfg.divisor[GRAY_W:1];
            quo_reg <= '0;
        end
        else if (cmd.step)
        begin
            rem_reg <= ge_c ? diff_c[DIV_W-1:0] : trial_c[DIV_W-1:0];
            num_reg <= {num_reg[GRAY_W-2:0], 1'b0};
            quo_reg <= {quo_reg[GRAY_W-2:0], ge_c};
        end
        if (cmd.load_out)
        begin
            gray_reg     <= sat_reg ? '1 : quo_reg;
            out_col_reg  <= bcol_reg[POS_W-1:0];
            out_row_reg  <= brow_reg[POS_W-1:0];
            row_done_reg <= rdone_reg;
        end
    end

    // Read the bin word at capture, write it back after the add
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
            rd_reg <= bin_sums[addr_c];
        if (cmd.accumulate && whole_reg)
            bin_sums[addr_reg] <= acc_c;
    end

    assign status.emit     = emit_reg;
    assign status.out_free = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign gray      = gray_reg;
    assign out_col   = out_col_reg;
    assign out_row   = out_row_reg;
    assign row_done  = row_done_reg;

    `GBDS_ASSERT_SAME(a_rem_below_divisor, cmd.step, sat_reg || (rem_reg < cfg.divisor), "partial remainder not below divisor")

endmodule
